// ----- sv/ldatt_pkg.sv -----
package ldatt_pkg;

  typedef enum logic [2:0] {
    OP_SURFACE     = 3'd0,
    OP_SKY         = 3'd1,
    OP_QUAKE       = 3'd2,
    OP_SKY_AMBIENT = 3'd3,
    OP_POINT       = 3'd4,
    OP_SPOT        = 3'd5
  } op_t;

  localparam int unsigned ROOT_W = 32;
  localparam int unsigned QUOT_W = 33;

  localparam logic [47:0] D2_ONE   = 48'h0000_0001_0000;
  localparam logic [33:0] DIV_CAP  = 34'h2_0000_0000;
  localparam logic [31:0] FALL_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] FALL_ONE = 32'h0001_0000;

  typedef struct packed {
    op_t         op;
    logic        cut;
    logic [47:0] d2;
    logic [31:0] kc;
    logic [31:0] kl;
    logic [31:0] kq;
  } ctx_t;

  typedef struct packed {
    op_t         op;
    logic        cut;
    logic        qcull;
    logic [31:0] qval;
  } post_t;

endpackage

// ----- sv/ldatt_sqrt_cell.sv -----
module ldatt_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               vld_in,
  input  logic [63:0]        rem_in,
  input  logic [31:0]        root_in,
  input  ldatt_pkg::ctx_t    ctx_in,
  output logic               vld,
  output logic [63:0]        rem,
  output logic [31:0]        root,
  output ldatt_pkg::ctx_t    ctx
);

  logic [65:0] trial;
  logic        ge;
  logic [63:0] rem_next;
  logic [31:0] root_next;

  assign trial     = ({34'd0, root_in} << (K + 1)) | (66'd1 << (2 * K));
  assign ge        = {2'b00, rem_in} >= trial;
  assign rem_next  = ge ? rem_in - trial[63:0] : rem_in;
  assign root_next = ge ? (root_in | (32'd1 << K)) : root_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem  <= rem_next;
      root <= root_next;
      ctx  <= ctx_in;
    end
  end

endmodule

// ----- sv/ldatt_div_cell.sv -----
module ldatt_div_cell #(
  parameter int unsigned K = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               vld_in,
  input  logic [47:0]        x_in,
  input  logic [47:0]        rem_in,
  input  logic [32:0]        q_in,
  input  ldatt_pkg::post_t   post_in,
  output logic               vld,
  output logic [47:0]        x,
  output logic [47:0]        rem,
  output logic [32:0]        q,
  output ldatt_pkg::post_t   post
);

  logic [48:0] sh;
  logic [48:0] diff;
  logic        ge;

  assign sh   = {rem_in, (K == ldatt_pkg::QUOT_W - 1) ? 1'b1 : 1'b0};
  assign ge   = sh >= {1'b0, x_in};
  assign diff = sh - {1'b0, x_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x    <= x_in;
      rem  <= ge ? diff[47:0] : sh[47:0];
      q    <= ge ? (q_in | (33'd1 << K)) : q_in;
      post <= post_in;
    end
  end

endmodule

// ----- sv/light_distance_attenuation.sv -----
// Distance falloff of one light at one lit point, Q16.16 result. One transaction is
// taken every cycle while the result side does not stall. The chain holds the input
// capture, squaring and summing stages, 32 square-root cells (one root bit each), the
// coefficient multiply and saturating-sum stages, 33 divider cells (one quotient bit
// each) and the output register. A stall of a valid result freezes the whole chain and
// raises item_stall.
module light_distance_attenuation (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  opcode,
  input  logic signed [23:0] delta_x,
  input  logic signed [23:0] delta_y,
  input  logic signed [23:0] delta_z,
  input  logic [23:0] cull_radius,
  input  logic [31:0] atten_constant,
  input  logic [31:0] atten_linear,
  input  logic [31:0] atten_quadratic,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] falloff,
  output logic        culled
);

  localparam int unsigned NS = ldatt_pkg::ROOT_W;
  localparam int unsigned ND = ldatt_pkg::QUOT_W;

  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // capture
  logic             a_vld;
  ldatt_pkg::op_t   a_op;
  logic [23:0]      a_ax, a_ay, a_az, a_rad;
  logic [31:0]      a_kc, a_kl, a_kq;

  // square
  logic             b_vld;
  ldatt_pkg::op_t   b_op;
  logic [47:0]      b_sx, b_sy, b_sz, b_r2;
  logic [31:0]      b_kc, b_kl, b_kq;

  // sum and cull compare
  logic             c_vld;
  ldatt_pkg::ctx_t  c_ctx;
  logic [47:0]      c_d2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= item_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  assign c_d2_next = b_sx + b_sy + b_sz;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op  <= ldatt_pkg::op_t'(opcode);
      a_ax  <= delta_x[23] ? (~delta_x + 24'd1) : delta_x;
      a_ay  <= delta_y[23] ? (~delta_y + 24'd1) : delta_y;
      a_az  <= delta_z[23] ? (~delta_z + 24'd1) : delta_z;
      a_rad <= cull_radius;
      a_kc  <= atten_constant;
      a_kl  <= atten_linear;
      a_kq  <= atten_quadratic;

      b_op  <= a_op;
      b_sx  <= a_ax * a_ax;
      b_sy  <= a_ay * a_ay;
      b_sz  <= a_az * a_az;
      b_r2  <= a_rad * a_rad;
      b_kc  <= a_kc;
      b_kl  <= a_kl;
      b_kq  <= a_kq;

      c_ctx.op  <= b_op;
      c_ctx.cut <= (b_r2 != 48'd0) && (c_d2_next > b_r2);
      c_ctx.d2  <= c_d2_next;
      c_ctx.kc  <= b_kc;
      c_ctx.kl  <= b_kl;
      c_ctx.kq  <= b_kq;
    end
  end

  // square-root chain
  logic             sq_vld  [0:NS];
  logic [63:0]      sq_rem  [0:NS];
  logic [31:0]      sq_root [0:NS];
  ldatt_pkg::ctx_t  sq_ctx  [0:NS];

  assign sq_vld[0]  = c_vld;
  assign sq_rem[0]  = {c_ctx.d2, 16'd0};
  assign sq_root[0] = 32'd0;
  assign sq_ctx[0]  = c_ctx;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    ldatt_sqrt_cell #(.K(NS - 1 - i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .vld_in  (sq_vld[i]),
      .rem_in  (sq_rem[i]),
      .root_in (sq_root[i]),
      .ctx_in  (sq_ctx[i]),
      .vld     (sq_vld[i+1]),
      .rem     (sq_rem[i+1]),
      .root    (sq_root[i+1]),
      .ctx     (sq_ctx[i+1])
    );
  end

  logic [31:0]      root_dist;
  ldatt_pkg::ctx_t  sctx;
  assign root_dist = sq_root[NS];
  assign sctx      = sq_ctx[NS];

  // multiply
  logic             d_vld;
  ldatt_pkg::post_t d_post;
  logic [47:0]      d_d2;
  logic [31:0]      d_kc;
  logic [63:0]      d_lin, d_plo;
  logic [47:0]      d_phi;

  // quadratic term and first saturating sum
  logic             e_vld;
  ldatt_pkg::post_t e_post;
  logic [47:0]      e_d2;
  logic [47:0]      e_quad;
  logic [33:0]      e_den;
  logic [79:0]      e_prod;
  logic [48:0]      e_sum;

  // second sum and divisor select
  logic             f_vld;
  ldatt_pkg::post_t f_post;
  logic [47:0]      f_x;
  logic [48:0]      f_sum;
  logic [33:0]      f_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= sq_vld[NS];
      e_vld <= d_vld;
      f_vld <= e_vld;
    end
  end

  assign e_prod = {d_phi, 32'd0} + {16'd0, d_plo};
  assign e_sum  = {17'd0, d_kc} + {1'b0, d_lin[63:16]};
  assign f_sum  = {15'd0, e_den} + {1'b0, e_quad};
  assign f_den  = (f_sum > {15'd0, ldatt_pkg::DIV_CAP}) ? ldatt_pkg::DIV_CAP : f_sum[33:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_post.op    <= sctx.op;
      d_post.cut   <= sctx.cut;
      d_post.qcull <= sctx.kl < root_dist;
      d_post.qval  <= sctx.kl - root_dist;
      d_d2         <= sctx.d2;
      d_kc         <= sctx.kc;
      d_lin        <= sctx.kl * root_dist;
      d_plo        <= sctx.kq * sctx.d2[31:0];
      d_phi        <= sctx.kq * sctx.d2[47:32];

      e_post <= d_post;
      e_d2   <= d_d2;
      e_quad <= (e_prod[79:64] != 16'd0) ? {14'd0, ldatt_pkg::DIV_CAP} : e_prod[63:16];
      e_den  <= (e_sum > {15'd0, ldatt_pkg::DIV_CAP}) ? ldatt_pkg::DIV_CAP : e_sum[33:0];

      f_post <= e_post;
      if (e_post.op == ldatt_pkg::OP_SURFACE) begin
        f_x <= (e_d2 < ldatt_pkg::D2_ONE) ? ldatt_pkg::D2_ONE : e_d2;
      end else begin
        f_x <= {14'd0, f_den};
      end
    end
  end

  // divider chain
  logic             dv_vld  [0:ND];
  logic [47:0]      dv_x    [0:ND];
  logic [47:0]      dv_rem  [0:ND];
  logic [32:0]      dv_q    [0:ND];
  ldatt_pkg::post_t dv_post [0:ND];

  assign dv_vld[0]  = f_vld;
  assign dv_x[0]    = f_x;
  assign dv_rem[0]  = 48'd0;
  assign dv_q[0]    = 33'd0;
  assign dv_post[0] = f_post;

  for (genvar j = 0; j < ND; j++) begin : g_div
    ldatt_div_cell #(.K(ND - 1 - j)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .vld_in  (dv_vld[j]),
      .x_in    (dv_x[j]),
      .rem_in  (dv_rem[j]),
      .q_in    (dv_q[j]),
      .post_in (dv_post[j]),
      .vld     (dv_vld[j+1]),
      .x       (dv_x[j+1]),
      .rem     (dv_rem[j+1]),
      .q       (dv_q[j+1]),
      .post    (dv_post[j+1])
    );
  end

  ldatt_pkg::post_t gp;
  logic [31:0]      recip;
  logic [31:0]      fall_next;
  logic             cull_next;

  assign gp    = dv_post[ND];
  assign recip = (dv_x[ND] == 48'd0 || dv_q[ND][32]) ? ldatt_pkg::FALL_MAX : dv_q[ND][31:0];

  always_comb begin
    fall_next = ldatt_pkg::FALL_ONE;
    cull_next = 1'b0;
    case (gp.op)
      ldatt_pkg::OP_SURFACE, ldatt_pkg::OP_POINT, ldatt_pkg::OP_SPOT: begin
        if (gp.cut) begin
          fall_next = 32'd0;
          cull_next = 1'b1;
        end else begin
          fall_next = recip;
        end
      end
      ldatt_pkg::OP_QUAKE: begin
        if (gp.qcull) begin
          fall_next = 32'd0;
          cull_next = 1'b1;
        end else begin
          fall_next = gp.qval;
        end
      end
      default: begin
        fall_next = ldatt_pkg::FALL_ONE;
        cull_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      falloff <= fall_next;
      culled  <= cull_next;
    end
  end

  a_cull_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && culled |-> falloff == 32'd0)
    else $error("culled result with nonzero falloff");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(falloff) && $stable(culled))
    else $error("stalled result changed");

  a_root_zero: assert property (@(posedge clk) disable iff (rst)
    sq_vld[NS] && sctx.d2 == 48'd0 |-> root_dist == 32'd0)
    else $error("nonzero root of zero distance");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> $stable(dv_vld[ND]))
    else $error("chain moved while stalled");

endmodule
